@@ hw/rtl/e2c_pkg.sv @@
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared types, constants and calendar tables for the epoch seconds to
// calendar converter.
// ----------------------------------------------------------------------------
package e2c_pkg;

    // Field widths
    localparam int SECS_W  = 32;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;

    // Serial divider widths: remainder holds any divisor, quotient word is the input
    localparam int REM_W = 17;
    localparam int NUM_W = 32;

    // Divisors
    localparam logic [REM_W-1:0] SECS_PER_DAY = 17'd86400;
    localparam logic [REM_W-1:0] SIXTY        = 17'd60;
    localparam logic [REM_W-1:0] PLAIN_YEAR   = 17'd365;
    localparam logic [REM_W-1:0] CYCLE_DAYS   = 17'd1461;

    // Calendar constants
    localparam logic [15:0]       PLAIN_DAYS    = 16'd730;
    localparam logic [YEAR_W-1:0] FIRST_YEAR    = 12'd1970;
    localparam logic [YEAR_W-1:0] FIRST_CYCLE   = 12'd1972;
    localparam logic [YEAR_W-1:0] LAST_OK_YEAR  = 12'd2099;
    localparam logic [10:0]       LEAP_FOLD_DOY = 11'd59;
    localparam logic [MONTH_W-1:0] FEBRUARY     = 4'd1;
    localparam logic [MONTH_W-1:0] DECEMBER     = 4'd11;
    localparam logic [1:0]        LAST_CYCLE_YEAR = 2'd3;

    // Control from the sequencer to the serial divider
    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    // Days in each year of a four-year cycle that opens with a leap year
    function automatic logic [8:0] cycle_year_len(input logic [1:0] k);
        logic [8:0] len;
        case (k)
            2'd0:    len = 9'd366;
            default: len = 9'd365;
        endcase
        return len;
    endfunction

    // Days in each month of a common year, January is zero
    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] mon);
        logic [4:0] len;
        case (mon) inside
            4'd1:                      len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ hw/rtl/e2c_seconds_if.sv @@
// ----------------------------------------------------------------------------
// e2c_seconds_if
// Valid/ready channel carrying a count of seconds since 1970-01-01 00:00:00.
// ----------------------------------------------------------------------------
interface e2c_seconds_if;
    logic                       valid;
    logic                       ready;
    logic [e2c_pkg::SECS_W-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

@@ hw/rtl/e2c_date_if.sv @@
// ----------------------------------------------------------------------------
// e2c_date_if
// Valid/ready channel carrying a calendar date and time of day.
// ----------------------------------------------------------------------------
interface e2c_date_if;
    logic                        valid;
    logic                        ready;
    logic [e2c_pkg::SEC_W-1:0]   second;
    logic [e2c_pkg::MIN_W-1:0]   minute;
    logic [e2c_pkg::HOUR_W-1:0]  hour;
    logic [e2c_pkg::DAY_W-1:0]   day;
    logic [e2c_pkg::MONTH_W-1:0] month;
    logic [e2c_pkg::YEAR_W-1:0]  year;
    logic                        out_of_range;

    modport source (output valid, output second, output minute, output hour,
                    output day, output month, output year, output out_of_range,
                    input ready);
    modport sink   (input valid, input second, input minute, input hour,
                    input day, input month, input year, input out_of_range,
                    output ready);
endinterface

@@ hw/rtl/e2c_serial_div.sv @@
// ----------------------------------------------------------------------------
// e2c_serial_div
// Restoring divider, one quotient bit per cycle with step set. The dividend
// is loaded left-aligned; quotient bits shift in at the bottom as dividend
// bits leave the top, so after n steps the low n bits hold the quotient.
// ----------------------------------------------------------------------------
module e2c_serial_div (
    input  logic                       clk,
    input  e2c_pkg::div_ctrl_t         ctrl,
    input  logic [e2c_pkg::REM_W-1:0]  load_rem,
    input  logic [e2c_pkg::NUM_W-1:0]  load_num,
    input  logic [e2c_pkg::REM_W-1:0]  divisor,
    output logic [e2c_pkg::NUM_W-1:0]  quo,
    output logic [e2c_pkg::REM_W-1:0]  rem
);
    import e2c_pkg::*;

    logic [NUM_W-1:0] num_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;

    // Bring down the next dividend bit and try the subtraction
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, divisor};

    // Load operands or advance one bit
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= load_rem;
            num_reg <= load_num;
        end
        else if (ctrl.step)
        begin
            if (diff[REM_W])
            begin
                rem_reg <= trial[REM_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            end
            else
            begin
                rem_reg <= diff[REM_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], 1'b1};
            end
        end
    end

    assign quo = num_reg;
    assign rem = rem_reg;

endmodule

@@ hw/rtl/epoch_seconds_to_calendar_core.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Converts seconds since 1970-01-01 00:00:00 into second, minute, hour, day,
// month and year under the every-fourth-year leap rule.
// ----------------------------------------------------------------------------
// A conversion runs four divisions on a single bit-serial restoring divider
// (16 steps by 86400, 17 and 11 steps by 60, then 10 steps by 365 or 16
// steps by 1461) at one quotient bit per cycle, each followed by an unload,
// then a year walk in the four-year cycle, a leap-day fold, a month walk and
// a load into the output register.
// One item is in flight at a time; the input is ready again as soon as the
// previous result lands in the output register, even while that result waits
// to be taken.
// Results past 2099-12-31 23:59:59 are still converted by the same rule and
// carry out_of_range.
module epoch_seconds_to_calendar_core (
    input  logic          clk,
    input  logic          rst_n,
    e2c_seconds_if.sink   seconds_ch,
    e2c_date_if.source    date_ch
);
    import e2c_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DAY   = 9'b000000010,
        ST_SEC   = 9'b000000100,
        ST_MIN   = 9'b000001000,
        ST_YEAR  = 9'b000010000,
        ST_CYCLE = 9'b000100000,
        ST_LEAP  = 9'b001000000,
        ST_MONTH = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;

    logic [15:0]        days_reg, days_next;
    logic               plain_reg, plain_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [10:0]        doy_reg, doy_next;
    logic [1:0]         k_reg, k_next;
    logic [MONTH_W-1:0] mon_reg, mon_next;
    logic               leap_reg, leap_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic [HOUR_W-1:0]  hour_reg, hour_next;

    logic [SEC_W-1:0]   o_sec_reg;
    logic [MIN_W-1:0]   o_min_reg;
    logic [HOUR_W-1:0]  o_hour_reg;
    logic [DAY_W-1:0]   o_day_reg;
    logic [MONTH_W-1:0] o_month_reg;
    logic [YEAR_W-1:0]  o_year_reg;
    logic               o_oor_reg;

    div_ctrl_t          div_ctrl;
    logic [REM_W-1:0]   div_load_rem;
    logic [NUM_W-1:0]   div_load_num;
    logic [REM_W-1:0]   div_divisor;
    logic [NUM_W-1:0]   div_quo;
    logic [REM_W-1:0]   div_rem;

    logic               in_xfer;
    logic               out_load;
    logic [15:0]        rest_days;
    logic [8:0]         cyc_len;
    logic [4:0]         mon_len;

    assign in_xfer  = seconds_ch.valid && seconds_ch.ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || date_ch.ready);
    assign rest_days = days_reg - PLAIN_DAYS;
    assign cyc_len   = cycle_year_len(k_reg);
    assign mon_len   = month_len(mon_reg);

    // Select the divisor for the current division
    always_comb
    begin
        case (state_reg)
            ST_DAY:  div_divisor = SECS_PER_DAY;
            ST_YEAR: div_divisor = plain_reg ? PLAIN_YEAR : CYCLE_DAYS;
            default: div_divisor = SIXTY;
        endcase
    end

    e2c_serial_div u_div (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .load_rem (div_load_rem),
        .load_num (div_load_num),
        .divisor  (div_divisor),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // Sequence the divisions and the calendar walks
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        days_next    = days_reg;
        plain_next   = plain_reg;
        year_next    = year_reg;
        doy_next     = doy_reg;
        k_next       = k_reg;
        mon_next     = mon_reg;
        leap_next    = leap_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hour_next    = hour_reg;
        div_ctrl     = '0;
        div_load_rem = '0;
        div_load_num = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Preload the top half as partial remainder, it is below 86400
                if (in_xfer)
                begin
                    div_ctrl.load = 1'b1;
                    div_load_rem  = {1'b0, seconds_ch.epoch_seconds[31:16]};
                    div_load_num  = {seconds_ch.epoch_seconds[15:0], 16'b0};
                    cnt_next      = 5'd16;
                    state_next    = ST_DAY;
                end
            end
            ST_DAY:
            begin
                if (cnt_reg != 5'd0)
                begin
                    div_ctrl.step = 1'b1;
                    cnt_next      = cnt_reg - 5'd1;
                end
                else
                begin
                    days_next     = div_quo[15:0];
                    div_ctrl.load = 1'b1;
                    div_load_num  = {div_rem, 15'b0};
                    cnt_next      = 5'd17;
                    state_next    = ST_SEC;
                end
            end
            ST_SEC:
            begin
                if (cnt_reg != 5'd0)
                begin
                    div_ctrl.step = 1'b1;
                    cnt_next      = cnt_reg - 5'd1;
                end
                else
                begin
                    sec_next      = div_rem[SEC_W-1:0];
                    div_ctrl.load = 1'b1;
                    div_load_num  = {div_quo[10:0], 21'b0};
                    cnt_next      = 5'd11;
                    state_next    = ST_MIN;
                end
            end
            ST_MIN:
            begin
                if (cnt_reg != 5'd0)
                begin
                    div_ctrl.step = 1'b1;
                    cnt_next      = cnt_reg - 5'd1;
                end
                else
                begin
                    min_next      = div_rem[MIN_W-1:0];
                    hour_next     = div_quo[HOUR_W-1:0];
                    div_ctrl.load = 1'b1;
                    if (days_reg < PLAIN_DAYS)
                    begin
                        plain_next   = 1'b1;
                        div_load_num = {days_reg[9:0], 22'b0};
                        cnt_next     = 5'd10;
                    end
                    else
                    begin
                        plain_next   = 1'b0;
                        div_load_num = {rest_days, 16'b0};
                        cnt_next     = 5'd16;
                    end
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (cnt_reg != 5'd0)
                begin
                    div_ctrl.step = 1'b1;
                    cnt_next      = cnt_reg - 5'd1;
                end
                else
                begin
                    doy_next = div_rem[10:0];
                    k_next   = 2'd0;
                    if (plain_reg)
                    begin
                        year_next  = FIRST_YEAR + {11'b0, div_quo[0]};
                        state_next = ST_LEAP;
                    end
                    else
                    begin
                        year_next  = FIRST_CYCLE + {4'b0, div_quo[5:0], 2'b00};
                        state_next = ST_CYCLE;
                    end
                end
            end
            ST_CYCLE:
            begin
                // Walk 366, 365, 365 through the four-year cycle
                if (k_reg != LAST_CYCLE_YEAR && doy_reg >= {2'b0, cyc_len})
                begin
                    doy_next  = doy_reg - {2'b0, cyc_len};
                    year_next = year_reg + 12'd1;
                    k_next    = k_reg + 2'd1;
                end
                else
                begin
                    state_next = ST_LEAP;
                end
            end
            ST_LEAP:
            begin
                // Fold day 59 onward back by one in a leap year
                leap_next  = (year_reg[1:0] == 2'b00) && (doy_reg >= LEAP_FOLD_DOY);
                doy_next   = doy_reg - {10'b0, leap_next};
                mon_next   = '0;
                state_next = ST_MONTH;
            end
            ST_MONTH:
            begin
                if (mon_reg != DECEMBER && doy_reg >= {6'b0, mon_len})
                begin
                    doy_next = doy_reg - {6'b0, mon_len};
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the sink takes it
    assign out_valid_next = out_load || (out_valid_reg && !date_ch.ready);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        days_reg  <= days_next;
        plain_reg <= plain_next;
        year_reg  <= year_next;
        doy_reg   <= doy_next;
        k_reg     <= k_next;
        mon_reg   <= mon_next;
        leap_reg  <= leap_next;
        sec_reg   <= sec_next;
        min_reg   <= min_next;
        hour_reg  <= hour_next;
    end

    // Output register; restore February 29 on the way out
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_sec_reg   <= sec_reg;
            o_min_reg   <= min_reg;
            o_hour_reg  <= hour_reg;
            o_day_reg   <= doy_reg[DAY_W-1:0] + 5'd1
                           + {4'b0, leap_reg && (mon_reg == FEBRUARY)};
            o_month_reg <= mon_reg + 4'd1;
            o_year_reg  <= year_reg;
            o_oor_reg   <= year_reg > LAST_OK_YEAR;
        end
    end

    assign seconds_ch.ready     = (state_reg == ST_IDLE);
    assign date_ch.valid        = out_valid_reg;
    assign date_ch.second       = o_sec_reg;
    assign date_ch.minute       = o_min_reg;
    assign date_ch.hour         = o_hour_reg;
    assign date_ch.day          = o_day_reg;
    assign date_ch.month        = o_month_reg;
    assign date_ch.year         = o_year_reg;
    assign date_ch.out_of_range = o_oor_reg;

    // Checks
    a_start_day: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_DAY) && (cnt_reg == 5'd16))
        else $error("day division did not start after input transfer");

    a_day_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DAY) && (cnt_reg == 5'd0) |-> (div_quo[31:16] == 16'd0))
        else $error("day count overflows 16 bits");

    a_cycle_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CYCLE) |-> !plain_reg)
        else $error("cycle walk entered for a plain year");

    a_month_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (mon_reg <= DECEMBER) && (doy_reg < 11'd31))
        else $error("month walk left an invalid month or day");

    a_out_gate: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_valid_reg || date_ch.ready)
        else $error("result overwritten before transfer");

endmodule
